// ===== hdl/gde_pkg.sv =====
package gde_pkg;

  // Map cell codes
  typedef enum logic [1:0] {
    CELL_UNKNOWN = 2'd0,
    CELL_OPEN    = 2'd1,
    CELL_VISITED = 2'd2,
    CELL_WALL    = 2'd3
  } cell_t;

  // Move directions, also the neighbor order
  typedef enum logic [1:0] {
    DIR_DOWN  = 2'd0,
    DIR_UP    = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  // Turn sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL
  } state_t;

  // Configuration register indexes
  localparam logic REG_START_X = 1'b0;
  localparam logic REG_START_Y = 1'b1;

  localparam int        COORD_W     = 5;
  localparam logic [4:0] START_RESET = 5'd11;

  // One turn's result
  typedef struct packed {
    logic [1:0] move_dir;
    logic       move_valid;
    logic       backtracking;
    logic       finished;
    logic       edge_fault;
  } result_t;

endpackage

// ===== hdl/gde_ram.sv =====
module gde_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds data while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/gde_core.sv =====
module gde_core #(
  parameter int GRID_SIZE   = 32,
  parameter int STACK_DEPTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         restart,
  input  logic [gde_pkg::COORD_W-1:0]  start_x,
  input  logic [gde_pkg::COORD_W-1:0]  start_y,
  input  logic                         item_valid,
  input  logic [3:0]                   blk,
  output logic                         item_take,
  input  logic                         res_ready,
  output logic                         res_valid,
  output gde_pkg::result_t             res,
  output logic                         cfg_ok
);

  import gde_pkg::*;

  localparam int CW    = $clog2(GRID_SIZE);
  localparam int CELLS = GRID_SIZE * GRID_SIZE;
  localparam int MW    = $clog2(CELLS);
  localparam int SW    = $clog2(STACK_DEPTH);
  localparam int CNTW  = SW + 1;
  localparam int PW    = 2 * CW;

  // Saturate a start coordinate into the grid
  function automatic logic [CW-1:0] sat_coord(input logic [COORD_W-1:0] v);
    logic [CW-1:0] r;
    if (32'(v) >= GRID_SIZE) r = CW'(GRID_SIZE - 1);
    else                     r = CW'(v);
    return r;
  endfunction

  // Linear map index of a cell
  function automatic logic [MW-1:0] lin(input logic [CW-1:0] y, input logic [CW-1:0] x);
    return MW'(MW'(y) * MW'(GRID_SIZE) + MW'(x));
  endfunction

  state_t          state, state_next;
  logic [1:0]      rd_cnt;
  logic [3:0]      blk_r;
  cell_t           code_r [3];
  logic [CW-1:0]   cx, cy;
  logic [CNTW-1:0] count;
  logic            done;
  logic            clearing;
  logic [MW-1:0]   sweep;

  // Write-back queue of the four neighbor codes
  logic [MW-1:0]   wq_addr [4];
  cell_t           wq_code [4];
  logic [3:0]      wq_en;
  logic [1:0]      wq_ptr;
  logic            wq_busy;

  logic            map_re, map_we;
  logic [MW-1:0]   map_raddr, map_waddr;
  logic [1:0]      map_wdata, map_rdata;
  logic            stk_re, stk_we;
  logic [SW-1:0]   stk_raddr, stk_waddr;
  logic [PW-1:0]   stk_wdata, stk_rdata;

  logic [CW-1:0]   sx, sy;
  logic [MW-1:0]   start_lin;
  logic [MW-1:0]   base;
  logic [3:0]      ingrid;
  logic [MW-1:0]   naddr [4];
  logic [CW-1:0]   nx [4];
  logic [CW-1:0]   ny [4];
  cell_t           old [4];
  cell_t           newcode [4];
  logic [3:0]      open_ok;
  logic            room, fwd_any, last, done_now, fault, fire;
  logic [1:0]      fwd_dir, bt_dir;
  logic [CW-1:0]   tx, ty;
  logic [CNTW-1:0] cnt_m2;

  assign sx        = sat_coord(start_x);
  assign sy        = sat_coord(start_y);
  assign start_lin = lin(sy, sx);

  // Neighbor addresses around the walker
  always_comb begin
    base      = lin(cy, cx);
    ingrid[0] = (cy != CW'(GRID_SIZE - 1));
    ingrid[1] = (cy != '0);
    ingrid[2] = (cx != '0);
    ingrid[3] = (cx != CW'(GRID_SIZE - 1));
    naddr[0]  = base + MW'(GRID_SIZE);
    naddr[1]  = base - MW'(GRID_SIZE);
    naddr[2]  = base - MW'(1);
    naddr[3]  = base + MW'(1);
    nx[0] = cx;             ny[0] = cy + CW'(1);
    nx[1] = cx;             ny[1] = cy - CW'(1);
    nx[2] = cx - CW'(1);    ny[2] = cy;
    nx[3] = cx + CW'(1);    ny[3] = cy;
  end

  // Turn decision from the four codes
  always_comb begin
    old[0] = code_r[0];
    old[1] = code_r[1];
    old[2] = code_r[2];
    old[3] = cell_t'(map_rdata);
    room   = (count < CNTW'(STACK_DEPTH));
    for (int d = 0; d < 4; d++) begin
      open_ok[d] = ingrid[d] && !blk_r[d] &&
                   (old[d] == CELL_UNKNOWN || old[d] == CELL_OPEN);
    end
    fwd_any = room && (|open_ok);
    fwd_dir = DIR_DOWN;
    for (int d = 3; d >= 0; d--) begin
      if (open_ok[d]) fwd_dir = 2'(d);
    end
    for (int d = 0; d < 4; d++) begin
      if (blk_r[d])                             newcode[d] = CELL_WALL;
      else if (fwd_any && fwd_dir == 2'(d))     newcode[d] = CELL_VISITED;
      else if (old[d] == CELL_UNKNOWN)          newcode[d] = CELL_OPEN;
      else                                      newcode[d] = old[d];
    end
    fault    = |(~ingrid & ~blk_r);
    last     = (count <= CNTW'(1));
    done_now = !fwd_any && last;
  end

  // Backtrack target from the prefetched stack entry
  always_comb begin
    ty = stk_rdata[PW-1:CW];
    tx = stk_rdata[CW-1:0];
    if ({1'b0, ty} + (CW+1)'(1) == {1'b0, cy})      bt_dir = DIR_UP;
    else if ({1'b0, ty} == {1'b0, cy} + (CW+1)'(1)) bt_dir = DIR_DOWN;
    else if ({1'b0, tx} + (CW+1)'(1) == {1'b0, cx}) bt_dir = DIR_LEFT;
    else if ({1'b0, tx} == {1'b0, cx} + (CW+1)'(1)) bt_dir = DIR_RIGHT;
    else                                            bt_dir = DIR_DOWN;
  end

  assign cnt_m2 = count - CNTW'(2);
  assign cfg_ok = clearing || (state == ST_IDLE && !wq_busy && !item_valid);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!clearing && item_valid && !done) state_next = ST_READ;
      end
      ST_READ: begin
        if (rd_cnt == 2'd3) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (res_ready) begin
          state_next = (item_valid && !done_now) ? ST_READ : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    item_take = 1'b0;
    res_valid = 1'b0;
    res       = '0;
    fire      = 1'b0;
    map_re    = 1'b0;
    stk_re    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (!clearing && item_valid) begin
          if (!done) begin
            item_take = 1'b1;
          end else if (res_ready) begin
            item_take    = 1'b1;
            res_valid    = 1'b1;
            res.finished = 1'b1;
          end
        end
      end
      ST_READ: begin
        map_re = 1'b1;
        stk_re = (rd_cnt == 2'd0);
      end
      ST_EVAL: begin
        if (res_ready) begin
          fire           = 1'b1;
          res_valid      = 1'b1;
          res.edge_fault = fault;
          if (fwd_any) begin
            res.move_dir   = fwd_dir;
            res.move_valid = 1'b1;
          end else if (last) begin
            res.finished = 1'b1;
          end else begin
            res.move_dir     = bt_dir;
            res.move_valid   = 1'b1;
            res.backtracking = 1'b1;
          end
          item_take = item_valid && !done_now;
        end
      end
      default: ;
    endcase
  end

  assign map_raddr = naddr[rd_cnt];
  assign stk_raddr = cnt_m2[SW-1:0];

  // Map write: clearing pass, else queued neighbor codes
  always_comb begin
    map_we    = 1'b0;
    map_waddr = wq_addr[wq_ptr];
    map_wdata = wq_code[wq_ptr];
    if (clearing) begin
      map_we    = 1'b1;
      map_waddr = sweep;
      map_wdata = (sweep == start_lin) ? CELL_VISITED : CELL_UNKNOWN;
    end else if (wq_busy && wq_en[wq_ptr]) begin
      map_we = 1'b1;
    end
  end

  // Stack write: start entry during clearing, else push
  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = count[SW-1:0];
    stk_wdata = {ny[fwd_dir], nx[fwd_dir]};
    if (clearing) begin
      stk_we    = 1'b1;
      stk_waddr = '0;
      stk_wdata = {sy, sx};
    end else if (fire && fwd_any) begin
      stk_we = 1'b1;
    end
  end

  // Sequencer, walker and queue registers
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state    <= ST_IDLE;
      clearing <= 1'b1;
      sweep    <= '0;
      done     <= 1'b0;
      count    <= CNTW'(1);
      wq_busy  <= 1'b0;
      wq_ptr   <= '0;
      rd_cnt   <= '0;
    end else begin
      state <= state_next;

      if (clearing) begin
        cx <= sx;
        cy <= sy;
        if (sweep == MW'(CELLS - 1)) clearing <= 1'b0;
        else                         sweep    <= sweep + MW'(1);
      end

      if (state == ST_READ) begin
        rd_cnt <= rd_cnt + 2'd1;
        if (rd_cnt != 2'd0) code_r[rd_cnt - 2'd1] <= cell_t'(map_rdata);
      end

      if (item_take) begin
        blk_r  <= blk;
        rd_cnt <= '0;
      end

      if (wq_busy) begin
        wq_ptr <= wq_ptr + 2'd1;
        if (wq_ptr == 2'd3) wq_busy <= 1'b0;
      end

      if (fire) begin
        wq_busy <= 1'b1;
        wq_ptr  <= '0;
        wq_en   <= ingrid;
        for (int d = 0; d < 4; d++) begin
          wq_addr[d] <= naddr[d];
          wq_code[d] <= newcode[d];
        end
        if (fwd_any) begin
          count <= count + CNTW'(1);
          cx    <= nx[fwd_dir];
          cy    <= ny[fwd_dir];
        end else if (last) begin
          count <= '0;
          done  <= 1'b1;
        end else begin
          count <= count - CNTW'(1);
          cx    <= tx;
          cy    <= ty;
        end
      end
    end
  end

  gde_ram #(.WIDTH(2), .DEPTH(CELLS)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (map_re),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  gde_ram #(.WIDTH(PW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // The previous turn's write-back has drained before a decision
  a_wq_drained: assert property (@(posedge clk) disable iff (rst)
    state == ST_EVAL |-> !wq_busy)
    else $error("write-back queue still busy at decision");

  // A pending write never targets the cell being read
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (map_re && map_we && !clearing) |-> map_raddr != map_waddr)
    else $error("map read and write hit the same cell");

  // Stack holds at least the walker's cell until finished
  a_count: assert property (@(posedge clk) disable iff (rst)
    (!clearing && !done) |-> (count != '0 && count <= CNTW'(STACK_DEPTH)))
    else $error("stack count out of range");

  // No map reads or decisions once finished
  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    done |-> (state != ST_READ && state != ST_EVAL))
    else $error("sequencer active after finish");

  // Results only go to a free output slot
  a_res_slot: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_ready)
    else $error("result issued into a full output slot");

endmodule

// ===== hdl/grid_dfs_explorer.sv =====
// Channel  Handshake               Payload
// in       in_valid / in_ready     blocked_down, blocked_up, blocked_left, blocked_right
// out      out_valid / out_ready   move_dir, move_valid, backtracking, finished, edge_fault
// cfg      cfg_valid / cfg_ready   cfg_index (0 start_x, 1 start_y), cfg_data
//
// A turn in the core is four neighbor reads through the map's single read port, then a
// decision; map write-back overlaps the next turn's reads. From an idle core a result
// passes the input buffer, the four reads, the decision and the output register. After
// finish, each buffered input goes straight out as a finished result; a new input is
// taken only once the buffered one is consumed. Reset and every start register write
// clear all GRID_SIZE*GRID_SIZE map cells; meanwhile one input is buffered, not processed.
// A waiting result stalls the decision cycle; the input buffer still takes one transfer.
module grid_dfs_explorer #(
  parameter int GRID_SIZE   = 32,
  parameter int STACK_DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        blocked_down,
  input  logic                        blocked_up,
  input  logic                        blocked_left,
  input  logic                        blocked_right,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  move_dir,
  output logic                        move_valid,
  output logic                        backtracking,
  output logic                        finished,
  output logic                        edge_fault,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [gde_pkg::COORD_W-1:0] cfg_data
);

  import gde_pkg::*;

  logic               pend;
  logic [3:0]         blk_buf;
  logic               item_take;
  logic               res_ready, res_valid;
  result_t            res, out_res;
  logic               cfg_ok, cfg_xfer;
  logic [COORD_W-1:0] start_x, start_y;

  assign in_ready  = !pend;
  assign res_ready = !out_valid || out_ready;
  assign cfg_ready = cfg_ok;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  // Input buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (in_valid && in_ready) begin
      pend    <= 1'b1;
      blk_buf <= {blocked_right, blocked_left, blocked_up, blocked_down};
    end else if (item_take) begin
      pend <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
      out_res   <= res;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign move_dir     = out_res.move_dir;
  assign move_valid   = out_res.move_valid;
  assign backtracking = out_res.backtracking;
  assign finished     = out_res.finished;
  assign edge_fault   = out_res.edge_fault;

  // Start registers; a transfer restarts exploration
  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= START_RESET;
      start_y <= START_RESET;
    end else if (cfg_xfer) begin
      case (cfg_index)
        REG_START_X: start_x <= cfg_data;
        REG_START_Y: start_y <= cfg_data;
        default: ;
      endcase
    end
  end

  gde_core #(.GRID_SIZE(GRID_SIZE), .STACK_DEPTH(STACK_DEPTH)) u_core (
    .clk        (clk),
    .rst        (rst),
    .restart    (cfg_xfer),
    .start_x    (start_x),
    .start_y    (start_y),
    .item_valid (pend),
    .blk        (blk_buf),
    .item_take  (item_take),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .res        (res),
    .cfg_ok     (cfg_ok)
  );

endmodule
